// ----- sv/tkr_pkg.sv -----
// ----------------------------------------------------------------------------
// tkr_pkg
// Shared types and codes for the top-k ranking tracker.
// ----------------------------------------------------------------------------
package tkr_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REWIND = 2'd1;
  localparam logic [1:0] CMD_NEXT   = 2'd2;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_REWOUND = 3'd3;
  localparam logic [2:0] ST_ENTRY   = 3'd4;
  localparam logic [2:0] ST_END     = 3'd5;

  typedef struct packed {
    logic [6:0]  score;
    logic [31:0] votes;
    logic [11:0] year;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  item_score;
    logic [31:0] item_votes;
    logic [11:0] item_year;
    logic [15:0] item_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  entry_count;
    logic [6:0]  out_score;
    logic [31:0] out_votes;
    logic [11:0] out_year;
    logic [15:0] out_tag;
  } out_item_t;

endpackage

// ----- sv/tkr_if.sv -----
// ----------------------------------------------------------------------------
// tkr_if
// Valid/ready channels for commands and results of the ranking tracker.
// ----------------------------------------------------------------------------
interface tkr_in_if;
  logic             valid;
  logic             ready;
  tkr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tkr_out_if;
  logic               valid;
  logic               ready;
  tkr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/top_k_ranking_tracker.sv -----
// ----------------------------------------------------------------------------
// top_k_ranking_tracker
// Keeps the best RANK_DEPTH items sorted by score, then votes, in one RAM.
// ----------------------------------------------------------------------------
// Usage: commands arrive on in_ch (insert, rewind, next), one result per
// command leaves on out_ch with status, entry count and, for next, the entry.
// One command is worked on at a time; in_ch.ready is high only while the
// block is idle and the result register is free or being drained.
// Command flow, paced by the entry RAM (one read and one write per cycle,
// registered read data):
//   rewind and ignored codes: result valid the cycle after the transfer;
//   the next command can be taken while that result is drained
//   next: entry read, captured in S_RD, sent to the output from S_OUT
//   insert: entries scanned one per cycle up to the insertion point or a
//   duplicate, entries below moved down (read then write each), item written
// Reset clears entry count and read position; RAM contents are not cleared,
// only entries below the count are ever read.
// A stalled receiver holds the result in the output register; the block
// then waits before taking the next command.
// ----------------------------------------------------------------------------
module top_k_ranking_tracker #(
  parameter int RANK_DEPTH = 100
) (
  input logic       clk,
  input logic       rst_n,
  tkr_in_if.sink    in_ch,
  tkr_out_if.source out_ch
);

  localparam int CW = $clog2(RANK_DEPTH + 1);
  localparam int AW = (RANK_DEPTH > 1) ? $clog2(RANK_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(RANK_DEPTH);
  localparam logic [CW-1:0] LAST_C  = CW'(RANK_DEPTH - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_SH_RD = 3'd2;
  localparam logic [2:0] S_SH_WR = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [CW-1:0]      held_r, held_nxt;
  logic [CW-1:0]      rpos_r, rpos_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  tkr_pkg::entry_t    item_r, item_nxt;
  tkr_pkg::out_item_t res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  tkr_pkg::out_item_t out_data_r, out_data_nxt;

  tkr_pkg::entry_t    mem [RANK_DEPTH];
  tkr_pkg::entry_t    rd_data_r;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               we;
  tkr_pkg::entry_t    wr_data;

  logic               free, acc, gt, eq;
  logic [CW-1:0]      idx_inc, idx_dec, held_inc, top;
  logic [CW:0]        rp1;
  tkr_pkg::entry_t    zero_e;

  function automatic tkr_pkg::out_item_t mk_res(logic [2:0] st, logic [CW-1:0] cnt,
                                                tkr_pkg::entry_t e);
    tkr_pkg::out_item_t r;
    r.status      = st;
    r.entry_count = 7'(cnt);
    r.out_score   = e.score;
    r.out_votes   = e.votes;
    r.out_year    = e.year;
    r.out_tag     = e.tag;
    return r;
  endfunction

  assign zero_e   = '0;
  assign free     = !out_valid_r || out_ch.ready;
  assign acc      = in_ch.valid && in_ch.ready;
  assign idx_inc  = idx_r + 1'b1;
  assign idx_dec  = idx_r - 1'b1;
  assign held_inc = (held_r < DEPTH_C) ? held_r + 1'b1 : held_r;
  assign top      = (held_r < DEPTH_C) ? held_r : LAST_C;
  assign rp1      = (pos_r <= rpos_r) ? {1'b0, rpos_r} + 1'b1 : {1'b0, rpos_r};

  // ranking compare of the held item against the entry just read
  assign gt = (item_r.score > rd_data_r.score) ||
              (item_r.score == rd_data_r.score && item_r.votes > rd_data_r.votes);
  assign eq = (item_r.score == rd_data_r.score) && (item_r.votes == rd_data_r.votes);

  assign in_ch.ready = (state_r == S_IDLE) && free;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    rpos_nxt      = rpos_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    rd_addr       = idx_r[AW-1:0];
    we            = 1'b0;
    wr_addr       = idx_r[AW-1:0];
    wr_data       = rd_data_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_ch.data.cmd)
            tkr_pkg::CMD_INSERT: begin
              item_nxt.score = in_ch.data.item_score;
              item_nxt.votes = in_ch.data.item_votes;
              item_nxt.year  = in_ch.data.item_year;
              item_nxt.tag   = in_ch.data.item_tag;
              idx_nxt        = '0;
              pos_nxt        = '0;
              rd_addr        = '0;
              state_nxt      = (held_r == '0) ? S_SH_RD : S_SRCH;
            end
            tkr_pkg::CMD_REWIND: begin
              rpos_nxt      = '0;
              out_valid_nxt = 1'b1;
              out_data_nxt  = mk_res(tkr_pkg::ST_REWOUND, held_r, zero_e);
            end
            tkr_pkg::CMD_NEXT: begin
              if (rpos_r < held_r) begin
                rd_addr   = rpos_r[AW-1:0];
                state_nxt = S_RD;
              end else begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = mk_res(tkr_pkg::ST_END, held_r, zero_e);
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = mk_res(tkr_pkg::ST_END, held_r, zero_e);
            end
          endcase
        end
      end
      S_RD: begin
        res_nxt   = mk_res(tkr_pkg::ST_ENTRY, held_r, rd_data_r);
        rpos_nxt  = rpos_r + 1'b1;
        state_nxt = S_OUT;
      end
      S_SRCH: begin
        if (eq) begin
          res_nxt   = mk_res(tkr_pkg::ST_DUP, held_r, zero_e);
          state_nxt = S_OUT;
        end else if (gt) begin
          pos_nxt   = idx_r;
          idx_nxt   = top;
          state_nxt = S_SH_RD;
        end else if (idx_inc == held_r) begin
          // worse than every entry: append, or reject when full
          if (held_r == DEPTH_C) begin
            res_nxt   = mk_res(tkr_pkg::ST_FULL, held_r, zero_e);
            state_nxt = S_OUT;
          end else begin
            pos_nxt   = held_r;
            idx_nxt   = held_r;
            state_nxt = S_SH_RD;
          end
        end else begin
          idx_nxt = idx_inc;
          rd_addr = idx_inc[AW-1:0];
        end
      end
      S_SH_RD: begin
        if (idx_r > pos_r) begin
          rd_addr   = idx_dec[AW-1:0];
          state_nxt = S_SH_WR;
        end else begin
          we       = 1'b1;
          wr_addr  = pos_r[AW-1:0];
          wr_data  = item_r;
          held_nxt = held_inc;
          // reader stays on its entry, clamped to the new count
          rpos_nxt = (rp1 > {1'b0, held_inc}) ? held_inc : rp1[CW-1:0];
          res_nxt  = mk_res(tkr_pkg::ST_ADDED, held_inc, zero_e);
          state_nxt = S_OUT;
        end
      end
      S_SH_WR: begin
        we        = 1'b1;
        wr_addr   = idx_r[AW-1:0];
        wr_data   = rd_data_r;
        idx_nxt   = idx_dec;
        state_nxt = S_SH_RD;
      end
      S_OUT: begin
        if (free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      rpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      rpos_r      <= rpos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- sv/tkr_checker.sv -----
// ----------------------------------------------------------------------------
// tkr_checker
// Port-level checks on the ranking tracker, bound to the top level.
// ----------------------------------------------------------------------------
module tkr_checker #(
  parameter int RANK_DEPTH = 100
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input tkr_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= tkr_pkg::ST_END)
    else $error("status code out of range");

  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != tkr_pkg::ST_ENTRY |->
      out_data.out_score == '0 && out_data.out_votes == '0 &&
      out_data.out_year == '0 && out_data.out_tag == '0)
    else $error("payload not zero outside an entry read");

  a_added_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == tkr_pkg::ST_ADDED |->
      out_data.entry_count != '0 && int'(out_data.entry_count) <= RANK_DEPTH)
    else $error("entry count wrong after an add");

endmodule

bind top_k_ranking_tracker tkr_checker #(.RANK_DEPTH(RANK_DEPTH)) u_tkr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// ----- bench/tb_top_k_ranking_tracker.sv -----
// ----------------------------------------------------------------------------
// tb_top_k_ranking_tracker
// Drives insert, rewind and next commands into the ranking tracker and checks
// every result against a sorted list kept in the bench, with random gaps on
// both channels and a long result stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_top_k_ranking_tracker;

  localparam int DEPTH = 100;
  localparam int CYCLE_LIMIT = 2000000;
  // command code with no meaning, the block answers with end
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tkr_in_if  in_ch ();
  tkr_out_if out_ch ();

  top_k_ranking_tracker #(.RANK_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // bench copy of the ranked list
  tkr_pkg::entry_t    rank_list[DEPTH];
  int                 rank_held;
  int                 rank_pos;
  tkr_pkg::out_item_t expected_results[$];
  int                 fail_count;
  int                 cycle_count;
  int                 hold_off_cycles;
  int                 out_wait;
  bit                 out_gaps_on;

  function automatic int rank_compare(logic [6:0] s1, logic [31:0] v1,
                                      logic [6:0] s2, logic [31:0] v2);
    if (s1 != s2) return (s1 > s2) ? 1 : -1;
    if (v1 != v2) return (v1 > v2) ? 1 : -1;
    return 0;
  endfunction

  function automatic tkr_pkg::out_item_t predict_ranking(tkr_pkg::in_item_t it);
    tkr_pkg::out_item_t r;
    int slot;
    int c;
    r = '0;
    r.status = tkr_pkg::ST_END;
    case (it.cmd)
      tkr_pkg::CMD_INSERT: begin
        slot = rank_held;
        r.status = tkr_pkg::ST_ADDED;
        if (rank_held == DEPTH && rank_compare(it.item_score, it.item_votes,
            rank_list[DEPTH-1].score, rank_list[DEPTH-1].votes) < 0) begin
          r.status = tkr_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < rank_held; i++) begin
            c = rank_compare(it.item_score, it.item_votes,
                             rank_list[i].score, rank_list[i].votes);
            if (c == 0) begin
              r.status = tkr_pkg::ST_DUP;
              break;
            end
            if (c > 0) begin
              slot = i;
              break;
            end
          end
          if (r.status == tkr_pkg::ST_ADDED) begin
            for (int i = (rank_held < DEPTH ? rank_held : DEPTH - 1); i > slot; i--)
              rank_list[i] = rank_list[i-1];
            rank_list[slot] = '{it.item_score, it.item_votes, it.item_year, it.item_tag};
            if (slot <= rank_pos) rank_pos++;
            if (rank_held < DEPTH) rank_held++;
            if (rank_pos > rank_held) rank_pos = rank_held;
          end
        end
      end
      tkr_pkg::CMD_REWIND: begin
        rank_pos = 0;
        r.status = tkr_pkg::ST_REWOUND;
      end
      tkr_pkg::CMD_NEXT: begin
        if (rank_pos < rank_held) begin
          r.status = tkr_pkg::ST_ENTRY;
          r.out_score = rank_list[rank_pos].score;
          r.out_votes = rank_list[rank_pos].votes;
          r.out_year = rank_list[rank_pos].year;
          r.out_tag = rank_list[rank_pos].tag;
          rank_pos++;
        end
      end
      default: ;
    endcase
    r.entry_count = rank_held[6:0];
    return r;
  endfunction

  // valid stays high from one transfer to the next when there is no gap
  task automatic send_command(tkr_pkg::in_item_t it, int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(predict_ranking(it));
  endtask

  function automatic tkr_pkg::in_item_t make_cmd(logic [1:0] cmd, logic [6:0] s,
                                                 logic [31:0] v);
    tkr_pkg::in_item_t it;
    it.cmd = cmd;
    it.item_score = s;
    it.item_votes = v;
    it.item_year = 12'($urandom);
    it.item_tag = 16'($urandom);
    return it;
  endfunction

  // scores and votes drawn from narrow pools so ties and reorderings happen
  function automatic tkr_pkg::in_item_t random_insert();
    logic [6:0] s;
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: s = 7'($urandom);
      default: s = 7'($urandom_range(40, 60));
    endcase
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      default: v = $urandom_range(0, 7);
    endcase
    return make_cmd(tkr_pkg::CMD_INSERT, s, v);
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_directed();
    send_command(make_cmd(tkr_pkg::CMD_NEXT, 0, 0), 0);       // next before any rewind
    send_command(make_cmd(CMD_UNUSED, 7'h7F, '1), 0);         // ignored code
    send_command(make_cmd(tkr_pkg::CMD_INSERT, 0, 0), 0);
    send_command(make_cmd(tkr_pkg::CMD_INSERT, 7'h7F, 32'hFFFF_FFFF), 1);
    send_command(make_cmd(tkr_pkg::CMD_INSERT, 7'h7F, 32'hFFFF_FFFF), 0);  // duplicate
    send_command(make_cmd(tkr_pkg::CMD_INSERT, 7'd100, 32'h5555_5555), 0);
    send_command(make_cmd(tkr_pkg::CMD_INSERT, 7'h2A, 32'hAAAA_AAAA), 2);
    send_command(make_cmd(tkr_pkg::CMD_REWIND, 0, 0), 0);
    send_command(make_cmd(tkr_pkg::CMD_NEXT, 0, 0), 0);
    send_command(make_cmd(tkr_pkg::CMD_INSERT, 7'h7F, 32'd5), 0);  // ahead of reader
    send_command(make_cmd(tkr_pkg::CMD_INSERT, 7'd1, 32'd5), 0);   // behind reader
    for (int i = 0; i < 6; i++) send_command(make_cmd(tkr_pkg::CMD_NEXT, 0, 0), 0);
    send_command(make_cmd(tkr_pkg::CMD_REWIND, 0, 0), 3);
  endtask

  // fill to capacity, then hit eviction, full reject and tie with last entry
  task automatic test_full_store();
    tkr_pkg::entry_t last;
    while (rank_held < DEPTH) send_command(random_insert(), $urandom_range(0, 1));
    last = rank_list[DEPTH-1];
    send_command(make_cmd(tkr_pkg::CMD_INSERT, last.score, last.votes), 0);
    if (last.votes != 0 || last.score != 0)
      send_command(make_cmd(tkr_pkg::CMD_INSERT,
                            last.votes != 0 ? last.score : last.score - 7'd1,
                            last.votes != 0 ? last.votes - 32'd1 : last.votes), 0);
    send_command(make_cmd(tkr_pkg::CMD_REWIND, 0, 0), 0);
    for (int i = 0; i < DEPTH; i++) send_command(make_cmd(tkr_pkg::CMD_NEXT, 0, 0), 0);
    send_command(make_cmd(tkr_pkg::CMD_INSERT, 7'h7F, 32'd9), 0);   // evict while at end
    send_command(make_cmd(tkr_pkg::CMD_NEXT, 0, 0), 0);
  endtask

  task automatic test_random_mix(int n);
    tkr_pkg::in_item_t it;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: it = make_cmd(tkr_pkg::CMD_REWIND, 7'($urandom), $urandom);
        1, 2, 3: it = make_cmd(tkr_pkg::CMD_NEXT, 7'($urandom), $urandom);
        4: it = make_cmd(CMD_UNUSED, 7'($urandom), $urandom);
        default: it = random_insert();
      endcase
      send_command(it, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
    end
  endtask

  task automatic test_output_stall();
    hold_off_cycles = 300;
    for (int i = 0; i < 20; i++) send_command(random_insert(), 0);
    wait_drained();
  endtask

  // result side: a drawn wait before each result, plus a long hold-off when asked
  always @(posedge clk) begin
    int wait_n;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait <= 0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      wait_n = out_gaps_on ? $urandom_range(0, 19) : 0;
      out_wait <= wait_n;
      out_ch.ready <= (wait_n == 0);
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_ch.ready <= (out_wait == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tkr_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %h", out_ch.data);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.data.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_ch.data.status);
          fail_count++;
        end
        if (out_ch.data.entry_count !== want.entry_count) begin
          $error("entry_count expected %0d actual %0d", want.entry_count,
                 out_ch.data.entry_count);
          fail_count++;
        end
        if (out_ch.data.out_score !== want.out_score) begin
          $error("out_score expected %0d actual %0d", want.out_score, out_ch.data.out_score);
          fail_count++;
        end
        if (out_ch.data.out_votes !== want.out_votes) begin
          $error("out_votes expected %0d actual %0d", want.out_votes, out_ch.data.out_votes);
          fail_count++;
        end
        if (out_ch.data.out_year !== want.out_year) begin
          $error("out_year expected %0d actual %0d", want.out_year, out_ch.data.out_year);
          fail_count++;
        end
        if (out_ch.data.out_tag !== want.out_tag) begin
          $error("out_tag expected %0d actual %0d", want.out_tag, out_ch.data.out_tag);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rank_held = 0;
    rank_pos = 0;
    fail_count = 0;
    cycle_count = 0;
    hold_off_cycles = 0;
    out_gaps_on = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    out_gaps_on = 1'b1;
    test_output_stall();
    test_random_mix(150);
    wait_drained();                     // sender pauses until all results are in
    test_full_store();
    test_random_mix(150);
    out_gaps_on = 1'b0;
    test_random_mix(40);
    wait_drained();
    repeat (400) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
